FILE: rtl/core/sm3_hash_engine_unit_assert.svh
// Assertion macros used by the SM3 hash engine controller.
`ifndef SM3_HASH_ENGINE_UNIT_ASSERT_SVH
`define SM3_HASH_ENGINE_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SM3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SM3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/sm3_pkg.sv
// Package with the SM3 constants, helper functions and control types.
`default_nettype none
package sm3_pkg;

    localparam logic [31:0] SM3_T_LOW  = 32'h79CC4519;
    localparam logic [31:0] SM3_T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  SM3_PAD    = 8'h80;

    localparam logic [255:0] SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_bytes;  // write the selected bytes into the block buffer
        logic       pad_byte;    // write a single padding byte
        logic [7:0] pad_value;
        logic       start_comp;  // copy buffer and chaining value into the round state
        logic       round_en;    // perform one compression round
        logic       finish_comp; // fold the round state into the chaining value
        logic       restore_iv;  // restart with the initial value
    } sm3_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round;
    } sm3_status_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sm3_datapath.sv
// Datapath: block buffer, expansion window, round registers and chaining value.
`default_nettype none
module sm3_datapath
    import sm3_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sm3_cmd_t    cmd,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  byte_count,
    output sm3_status_t      status,
    output logic [255:0]     chain
);

    logic [31:0]  buf_reg [16];
    logic [31:0]  win_reg [16];
    logic [255:0] rr_reg;
    logic [255:0] cv_reg;
    logic [5:0]   fill_reg;
    logic [5:0]   round_reg;
    logic [31:0]  spill_word_reg;
    logic [5:0]   spill_fill_reg;
    logic [2:0]   spill_cnt_reg;

    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] wj, wj4, tcon, a12, ss1, ss2, ff, gg, tt1, tt2, nw;
    logic [31:0] w7, w13, w3, w10;

    assign {a, b, c, d, e, f, g, h} = rr_reg;
    assign status.fill  = fill_reg;
    assign status.round = round_reg;
    assign chain        = cv_reg;

    // One SM3 round, with the window indexed relative to the round counter.
    always_comb
    begin
        wj   = win_reg[round_reg[3:0]];
        wj4  = win_reg[round_reg[3:0] + 4'd4];
        w7   = win_reg[round_reg[3:0] + 4'd7];
        w13  = win_reg[round_reg[3:0] + 4'd13];
        w3   = win_reg[round_reg[3:0] + 4'd3];
        w10  = win_reg[round_reg[3:0] + 4'd10];
        tcon = (round_reg < 6'd16) ? SM3_T_LOW : SM3_T_HIGH;
        a12  = rotl32(a, 5'd12);
        ss1  = rotl32(a12 + e + rotl32(tcon, round_reg[4:0]), 5'd7);
        ss2  = ss1 ^ a12;
        if (round_reg < 6'd16)
        begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
        end
        else
        begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
        end
        tt1 = ff + d + ss2 + (wj ^ wj4);
        tt2 = gg + h + ss1 + wj;
        nw  = perm1(wj ^ w7 ^ rotl32(w13, 5'd15)) ^ rotl32(w3, 5'd7) ^ w10;
    end

    // Byte packing into the block buffer. Bytes of a word that run past the end of
    // the block are held back and written once the full block has been copied out.
    always_ff @(posedge clk)
    begin
        logic [6:0] pos;
        if (cmd.load_bytes)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pos = {1'b0, fill_reg} + 7'(i);
                if (3'(i) < byte_count && !pos[6])
                    buf_reg[pos[5:2]][8*(3-pos[1:0]) +: 8] <= data_word[8*(3-i) +: 8];
            end
            spill_word_reg <= data_word;
            spill_fill_reg <= fill_reg;
            spill_cnt_reg  <= byte_count;
        end
        else if (cmd.pad_byte)
        begin
            buf_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= cmd.pad_value;
        end
        else if (cmd.start_comp)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pos = {1'b0, spill_fill_reg} + 7'(i);
                if (3'(i) < spill_cnt_reg && pos[6])
                    buf_reg[pos[5:2]][8*(3-pos[1:0]) +: 8] <= spill_word_reg[8*(3-i) +: 8];
            end
            spill_cnt_reg <= '0;
        end
    end

    // Round state and expansion window.
    always_ff @(posedge clk)
    begin
        if (cmd.start_comp)
        begin
            win_reg <= buf_reg;
            rr_reg  <= cv_reg;
        end
        else if (cmd.round_en)
        begin
            win_reg[round_reg[3:0]] <= nw;
            rr_reg <= {tt1, a, rotl32(b, 5'd9), c, perm0(tt2), e, rotl32(f, 5'd19), g};
        end
    end

    // Control counters and chaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            round_reg <= '0;
            cv_reg    <= SM3_IV;
        end
        else
        begin
            if (cmd.load_bytes)
                fill_reg <= fill_reg + {3'b000, byte_count};
            else if (cmd.pad_byte)
                fill_reg <= fill_reg + 6'd1;
            else if (cmd.restore_iv)
                fill_reg <= '0;
            if (cmd.start_comp)
                round_reg <= '0;
            else if (cmd.round_en)
                round_reg <= round_reg + 6'd1;
            if (cmd.finish_comp)
                cv_reg <= cv_reg ^ rr_reg;
            else if (cmd.restore_iv)
                cv_reg <= SM3_IV;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sm3_ctrl.sv
// Controller: input and output handshakes, padding sequence and round counting.
`default_nettype none
module sm3_ctrl
    import sm3_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             ready,
    input  wire logic [2:0]  bytes_valid,
    input  wire logic        last_word,
    output logic [2:0]       byte_count,
    input  wire sm3_status_t status,
    input  wire logic [255:0] chain,
    output sm3_cmd_t         cmd,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             digest_end
);
    `include "sm3_hash_engine_unit_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
    } state_t;

    state_t       state_reg, state_next;
    logic [63:0]  bits_reg, bits_next;
    logic         final_reg, final_next;
    logic         marker_reg, marker_next;
    logic [3:0]   len_cnt_reg, len_cnt_next;
    logic [2:0]   idx_reg, idx_next;
    logic         ov_reg, ov_next;
    logic [255:0] dig_reg, dig_next;
    logic         accept;
    logic [2:0]   nb;
    logic [6:0]   sum;

    assign nb          = (bytes_valid > 3'd4) ? 3'd4 : bytes_valid;
    assign byte_count  = nb;
    assign sum         = {1'b0, status.fill} + {4'b0000, nb};
    assign ready       = (state_reg == ST_IDLE);
    assign accept      = valid && ready;
    assign out_valid   = ov_reg;
    assign digest_word = dig_reg[255:224];
    assign word_index  = idx_reg;
    assign digest_end  = (idx_reg == 3'd7);

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        bits_next    = bits_reg;
        final_next   = final_reg;
        marker_next  = marker_reg;
        len_cnt_next = len_cnt_reg;
        idx_next     = idx_reg;
        ov_next      = ov_reg;
        dig_next     = dig_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_bytes = 1'b1;
                    bits_next  = bits_reg + {58'd0, nb, 3'b000};
                    final_next = last_word;
                    if (sum[6])
                        state_next = ST_LOAD;
                    else if (last_word)
                        state_next = ST_PAD;
                end
            end
            ST_LOAD:
            begin
                // Copy the block and the chaining value into the round state.
                cmd.start_comp = 1'b1;
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (status.round == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                // Fold the round state into the chaining value and pick the next step.
                cmd.finish_comp = 1'b1;
                if (!final_reg)
                    state_next = ST_IDLE;
                else if (len_cnt_reg == 4'd8)
                    state_next = ST_EMIT;
                else
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                // Marker byte first, then zero bytes up to byte 56, then the length.
                cmd.pad_byte = 1'b1;
                if (!marker_reg)
                begin
                    cmd.pad_value = SM3_PAD;
                    marker_next   = 1'b1;
                end
                else if (len_cnt_reg == 4'd0 && status.fill != 6'd56)
                begin
                    cmd.pad_value = 8'h00;
                end
                else
                begin
                    cmd.pad_value = bits_reg[8*(3'd7 - len_cnt_reg[2:0]) +: 8];
                    len_cnt_next  = len_cnt_reg + 4'd1;
                end
                if (status.fill == 6'd63)
                    state_next = ST_LOAD;
            end
            ST_EMIT:
            begin
                // Hand out the digest once the previous one has drained.
                if (!ov_reg)
                begin
                    dig_next       = chain;
                    idx_next       = 3'd0;
                    ov_next        = 1'b1;
                    final_next     = 1'b0;
                    bits_next      = '0;
                    marker_next    = 1'b0;
                    len_cnt_next   = '0;
                    cmd.restore_iv = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (ov_reg && out_ready)
        begin
            dig_next = {dig_reg[223:0], 32'd0};
            idx_next = idx_reg + 3'd1;
            if (idx_reg == 3'd7)
                ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bits_reg    <= '0;
            final_reg   <= 1'b0;
            marker_reg  <= 1'b0;
            len_cnt_reg <= '0;
            idx_reg     <= '0;
            ov_reg      <= 1'b0;
            dig_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bits_reg    <= bits_next;
            final_reg   <= final_next;
            marker_reg  <= marker_next;
            len_cnt_reg <= len_cnt_next;
            idx_reg     <= idx_next;
            ov_reg      <= ov_next;
            dig_reg     <= dig_next;
        end
    end

    `SM3_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !ready)
    `SM3_ASSERT_NEXT(a_round_start, clk, rst_n, state_reg == ST_LOAD, status.round == 6'd0)
    `SM3_ASSERT_NEXT(a_out_hold, clk, rst_n, ov_reg && !out_ready, ov_reg && $stable(dig_reg))

endmodule
`default_nettype wire

FILE: rtl/core/sm3_hash_engine_unit.sv
// SM3 hash engine: 32-bit word in, eight 32-bit digest words out, one word a cycle
// while idle. A non-final word that leaves the block short of 64 bytes keeps the
// input ready; a block-ending word holds it low through load, 64 rounds, fold.
// A final word is padded one byte a cycle, each final block is compressed in turn,
// and the first digest word is output once the previous digest has drained.
// Reset is asynchronous, active low, and restores the SM3 initial value.
`default_nettype none
module sm3_hash_engine_unit
    import sm3_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  bytes_valid,
    input  wire logic        last_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             digest_end
);

    sm3_cmd_t     cmd;
    sm3_status_t  status;
    logic [255:0] chain;
    logic [2:0]   byte_count;

    sm3_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .bytes_valid(bytes_valid), .last_word(last_word), .byte_count(byte_count),
        .status(status), .chain(chain), .cmd(cmd), .out_valid(out_valid),
        .out_ready(out_ready), .digest_word(digest_word), .word_index(word_index),
        .digest_end(digest_end)
    );

    sm3_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .data_word(data_word),
        .byte_count(byte_count), .status(status), .chain(chain)
    );

endmodule
`default_nettype wire

FILE: test/tb_sm3_hash_engine_unit.sv
// Self-checking testbench for the SM3 hash engine, digest checked word by word.
`default_nettype none
module tb_sm3_hash_engine_unit;
    import sm3_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_end;
    } digest_out_t;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
        logic        has_known;   // a known digest word 0 is typed in
        logic [31:0] known_word0;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic [2:0]  bytes_valid;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_end;

    sm3_hash_engine_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_word(data_word), .bytes_valid(bytes_valid), .last_word(last_word),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .digest_end(digest_end)
    );

    // Predictor state.
    logic [31:0] hash_state [8];
    logic [31:0] msg_block [16];
    int unsigned fill_bytes;
    logic [63:0] bit_count;

    digest_out_t digest_queue [$];
    int          fail_count;
    bit          quiet_phase;
    bit          long_hold;

    // Clock and the run limit.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} << (n % 32);
        return d[63:32];
    endfunction

    // One SM3 compression of the buffered block into the hash state.
    task automatic compress_into_state();
        logic [31:0] w [16];
        logic [31:0] r [8];
        logic [31:0] wj, t, a12, s1, s2, ff, gg, t1, t2, nw, x;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = msg_block[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            r[i] = hash_state[i];
        end
        for (int j = 0; j < 64; j++)
        begin
            wj  = w[j % 16];
            t   = (j < 16) ? SM3_T_LOW : SM3_T_HIGH;
            a12 = rot_left(r[0], 12);
            s1  = rot_left(a12 + r[4] + rot_left(t, j), 7);
            s2  = s1 ^ a12;
            if (j < 16)
            begin
                ff = r[0] ^ r[1] ^ r[2];
                gg = r[4] ^ r[5] ^ r[6];
            end
            else
            begin
                ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                gg = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            t1 = ff + r[3] + s2 + (wj ^ w[(j + 4) % 16]);
            t2 = gg + r[7] + s1 + wj;
            x  = wj ^ w[(j + 7) % 16] ^ rot_left(w[(j + 13) % 16], 15);
            nw = x ^ rot_left(x, 15) ^ rot_left(x, 23)
                 ^ rot_left(w[(j + 3) % 16], 7) ^ w[(j + 10) % 16];
            w[j % 16] = nw;
            r[3] = r[2];
            r[2] = rot_left(r[1], 9);
            r[1] = r[0];
            r[0] = t1;
            r[7] = r[6];
            r[6] = rot_left(r[5], 19);
            r[5] = r[4];
            r[4] = t2 ^ rot_left(t2, 9) ^ rot_left(t2, 17);
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = hash_state[i] ^ r[i];
        end
    endtask

    task automatic append_byte(input logic [7:0] b);
        int sh;
        sh = 24 - 8 * (fill_bytes % 4);
        msg_block[fill_bytes / 4] = (msg_block[fill_bytes / 4] & ~(32'hFF << sh))
                                    | (32'(b) << sh);
        fill_bytes = (fill_bytes + 1) % 64;
        if (fill_bytes == 0)
            compress_into_state();
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = SM3_IV[255 - 32 * i -: 32];
        end
        fill_bytes = 0;
        bit_count  = '0;
    endtask

    // Predict the digest words caused by one accepted word.
    task automatic predict_word(input logic [31:0] d, input logic [2:0] nb, input logic l);
        int unsigned n;
        logic [63:0] len;
        digest_out_t e;
        n = (nb > 4) ? 4 : nb;
        for (int i = 0; i < n; i++)
        begin
            append_byte(d[31 - 8 * i -: 8]);
            bit_count = bit_count + 64'd8;
        end
        if (l)
        begin
            len = bit_count;
            append_byte(SM3_PAD);
            while (fill_bytes != 56)
                append_byte(8'h00);
            for (int i = 0; i < 8; i++)
                append_byte(len[63 - 8 * i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                e.digest_word = hash_state[i];
                e.word_index  = 3'(i);
                e.digest_end  = (i == 7);
                digest_queue = {digest_queue, e};
            end
            restart_hash();
        end
    endtask

    // Offer one word and wait until it is accepted.
    task automatic send_word(input logic [31:0] d, input logic [2:0] nb, input logic l);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_word   <= d;
        bytes_valid <= nb;
        last_word   <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_word(d, nb, l);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (digest_queue.size() != 0)
            @(posedge clk);
    endtask

    // Result checker: compare each accepted digest word with the oldest expectation.
    always @(posedge clk)
    begin
        digest_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_queue.size() == 0)
            begin
                $error("unexpected digest word %h", digest_word);
                fail_count++;
            end
            else
            begin
                e = digest_queue.pop_front();
                if (digest_word !== e.digest_word)
                begin
                    $error("digest_word expected %h actual %h", e.digest_word, digest_word);
                    fail_count++;
                end
                if (word_index !== e.word_index)
                begin
                    $error("word_index expected %0d actual %0d", e.word_index, word_index);
                    fail_count++;
                end
                if (digest_end !== e.digest_end)
                begin
                    $error("digest_end expected %0d actual %0d", e.digest_end, digest_end);
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure: random bursts, one long hold, none in the quiet phase.
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (1500) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge clk);
            end
        end
    end

    // Directed rows: empty message, "abc", extremes and special cases.
    stim_row_t dir_rows [] = '{
        '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'h1AB21D83},
        '{32'h61626300, 3'd3, 1'b1, 1'b1, 32'h66C7F0F4},
        '{32'hFFFFFFFF, 3'd4, 1'b1, 1'b0, 32'h0},
        '{32'h00000000, 3'd4, 1'b1, 1'b0, 32'h0},
        '{32'hA5A5A5A5, 3'd7, 1'b1, 1'b0, 32'h0},
        '{32'h12345678, 3'd5, 1'b0, 1'b0, 32'h0},
        '{32'hDEADBEEF, 3'd1, 1'b0, 1'b0, 32'h0},
        '{32'hCAFEF00D, 3'd2, 1'b0, 1'b0, 32'h0},
        '{32'h5A5A5A5A, 3'd0, 1'b0, 1'b0, 32'h0},
        '{32'h0F0F0F0F, 3'd3, 1'b1, 1'b0, 32'h0},
        '{32'h80000001, 3'd6, 1'b0, 1'b0, 32'h0},
        '{32'h7FFFFFFE, 3'd0, 1'b1, 1'b0, 32'h0}
    };

    initial
    begin
        int len;
        logic [2:0] nb;
        fail_count  = 0;
        quiet_phase = 1'b0;
        long_hold   = 1'b0;
        in_valid    = 1'b0;
        data_word   = '0;
        bytes_valid = '0;
        last_word   = 1'b0;
        rst_n       = 1'b0;
        restart_hash();
        for (int i = 0; i < 16; i++)
        begin
            msg_block[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed-in first words are checked against the predictor too.
        foreach (dir_rows[k])
        begin
            send_word(dir_rows[k].data, dir_rows[k].nbytes, dir_rows[k].last);
            if (dir_rows[k].has_known && digest_queue.size() >= 8
                && digest_queue[digest_queue.size() - 8].digest_word
                   !== dir_rows[k].known_word0)
            begin
                $error("digest_word expected %h actual %h", dir_rows[k].known_word0,
                       digest_queue[digest_queue.size() - 8].digest_word);
                fail_count++;
            end
        end
        // Messages that fill 55, 56 and 64 bytes exercise both padding layouts.
        for (int m = 55; m <= 64; m += (m == 56) ? 8 : 1)
        begin
            for (int b = 0; b < m; b += 4)
                send_word($urandom, (m - b >= 4) ? 3'd4 : 3'(m - b), (b + 4 >= m));
        end
        wait_drained();

        // Long receiver hold while the sender keeps going, so the input stalls.
        long_hold = 1'b1;
        for (int i = 0; i < 60; i++)
            send_word($urandom, 3'd4, (i % 20) == 19);
        wait_drained();

        // Random messages: mostly full words, a final word of random byte count, some noise.
        for (int i = 0; i < 330; )
        begin
            len = $urandom_range(0, 40);
            for (int b = 0; b < len; b++)
            begin
                case ($urandom_range(0, 9))
                    0: nb = 3'($urandom_range(0, 7));
                    1: nb = 3'($urandom_range(1, 3));
                    default: nb = 3'd4;
                endcase
                send_word($urandom, nb, 1'b0);
                i++;
            end
            send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
            i++;
            if (i > 280)
                quiet_phase = 1'b1;
        end
        wait_drained();
        repeat (200) @(posedge clk);

        if (fail_count == 0 && digest_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/sm3_pkg.sv
rtl/core/sm3_datapath.sv
rtl/core/sm3_ctrl.sv
rtl/core/sm3_hash_engine_unit.sv
test/tb_sm3_hash_engine_unit.sv
